>>> rtl/gtdf_pkg.sv
// ----------------------------------------------------------------------------
// gtdf_pkg
// Shared constants, request codes and the dither seed function for the
// gamma-corrected, temporally dithered LED frame store.
// ----------------------------------------------------------------------------
package gtdf_pkg;

    // Number of channel bytes walked on each refresh (1 to 64).
    localparam int NUM_BYTES   = 48;
    localparam int BANK_SIZE   = 64;
    localparam int POS_W       = $clog2(BANK_SIZE);
    localparam int FRAME_AW    = POS_W + 1;
    localparam int GAMMA_DEPTH = 256;

    localparam logic [7:0] DITHER_STEP = 8'd153;
    localparam logic [7:0] TPF_RESET   = 8'd4;

    typedef enum logic [1:0] {
        FUNC_GAMMA = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_DONE  = 2'd2,
        FUNC_TICK  = 2'd3
    } t_func;

    // Remainder value that a byte position holds after reset.
    function automatic logic [7:0] rem_init(input logic [POS_W-1:0] pos);
        logic [15:0] prod;
        prod = 16'(DITHER_STEP) * (16'(pos) + 16'd1);
        return prod[7:0];
    endfunction

endpackage

>>> rtl/gamma_temporal_dither_frame.sv
// ----------------------------------------------------------------------------
// gamma_temporal_dither_frame
// Double-buffered LED frame store with gamma lookup and per-byte temporal
// dithering, walked one byte at a time by a small sequencer.
// ----------------------------------------------------------------------------
// Gamma, write and complete requests are taken in the idle state, which
// the block does not leave, so it stays ready for the next request. A refresh
// tick walks every byte through the states frame read, gamma read and
// remainder update, stalling in the update while the result is not taken;
// no request is accepted until the walk ends. Reset is synchronous; frame and
// remainder stores use per-entry valid bits, so there is no clearing pass.
module gamma_temporal_dither_frame (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    // Request channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_func,
    input  logic [7:0]  i_index,
    input  logic [15:0] i_value,
    // Result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_led_byte,
    output logic [5:0]  o_position,
    output logic        o_last,
    output logic        o_swapped
);

    localparam int                             POS_W    = gtdf_pkg::POS_W;
    localparam int                             FRAME_AW = gtdf_pkg::FRAME_AW;
    localparam logic [POS_W-1:0]               LAST_POS = POS_W'(gtdf_pkg::NUM_BYTES - 1);
    localparam logic [7:0]                     NB_LIMIT = 8'(gtdf_pkg::NUM_BYTES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FRD,
        S_GRD,
        S_ADD
    } t_state;

    t_state r_state;

    logic [7:0]       r_tpf;
    logic             r_front;
    logic [7:0]       r_tick;
    logic             r_frame_ready;
    logic [POS_W-1:0] r_pos;

    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic [POS_W-1:0] r_out_pos;
    logic             r_out_last;
    logic             r_out_swapped;

    // Stores and their registered read data
    logic [15:0] r_gamma_mem [gtdf_pkg::GAMMA_DEPTH];
    logic [7:0]  r_frame_mem [2 * gtdf_pkg::BANK_SIZE];
    logic [7:0]  r_rem_mem   [gtdf_pkg::BANK_SIZE];

    logic [2*gtdf_pkg::BANK_SIZE-1:0] r_fvalid;
    logic [gtdf_pkg::BANK_SIZE-1:0]   r_rvalid;

    logic [15:0] r_gdata;
    logic [7:0]  r_fdata;
    logic        r_fdata_ok;
    logic [7:0]  r_rdata;
    logic        r_rdata_ok;

    logic                w_in_acc;
    logic                w_out_free;
    logic                w_step;
    logic                w_is_last;
    logic                w_fwrite;
    logic [FRAME_AW-1:0] w_fwaddr;
    logic [FRAME_AW-1:0] w_fraddr;
    logic [7:0]          w_pix;
    logic [7:0]          w_rem;
    logic [8:0]          n_sum;
    logic [8:0]          n_level_sum;
    logic [7:0]          n_level;
    logic [7:0]          n_tick;
    logic                n_swap;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == S_IDLE);
    assign w_in_acc    = i_valid && o_ready;
    assign w_out_free  = !r_out_valid || i_ready;
    assign w_step      = (r_state == S_ADD) && w_out_free;
    assign w_is_last   = (r_pos == LAST_POS);

    assign w_fwrite = w_in_acc && (i_func == gtdf_pkg::FUNC_WRITE) && (i_index < NB_LIMIT);
    assign w_fwaddr = {~r_front, i_index[POS_W-1:0]};
    assign w_fraddr = {r_front, r_pos};

    // A byte never written since reset reads as zero; a remainder never
    // updated reads as its seed value.
    assign w_pix = r_fdata_ok ? r_fdata : 8'd0;
    assign w_rem = r_rdata_ok ? r_rdata : gtdf_pkg::rem_init(r_pos);

    assign n_sum       = {1'b0, w_rem} + {1'b0, r_gdata[7:0]};
    assign n_level_sum = {1'b0, r_gdata[15:8]} + {8'd0, n_sum[8]};
    assign n_level     = n_level_sum[8] ? 8'hFF : n_level_sum[7:0];
    assign n_tick      = r_tick + 8'd1;
    assign n_swap      = r_frame_ready && (n_tick >= r_tpf);

    // Sequencer and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_tpf         <= gtdf_pkg::TPF_RESET;
            r_front       <= 1'b0;
            r_tick        <= 8'd0;
            r_frame_ready <= 1'b0;
            r_pos         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_tpf <= i_cfg_data;
            end
            if (r_out_valid && i_ready && !w_step) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        case (i_func)
                            gtdf_pkg::FUNC_DONE: begin
                                r_frame_ready <= 1'b1;
                            end
                            gtdf_pkg::FUNC_TICK: begin
                                r_pos   <= '0;
                                r_state <= S_FRD;
                            end
                            default: ;
                        endcase
                    end
                end
                S_FRD: begin
                    r_state <= S_GRD;
                end
                S_GRD: begin
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    if (w_out_free) begin
                        r_out_valid   <= 1'b1;
                        r_out_byte    <= n_level;
                        r_out_pos     <= r_pos;
                        r_out_last    <= w_is_last;
                        r_out_swapped <= w_is_last && n_swap;
                        if (w_is_last) begin
                            r_state <= S_IDLE;
                            if (n_swap) begin
                                r_front       <= ~r_front;
                                r_tick        <= 8'd0;
                                r_frame_ready <= 1'b0;
                            end else begin
                                r_tick <= n_tick;
                            end
                        end else begin
                            r_pos   <= r_pos + 1'b1;
                            r_state <= S_FRD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Valid bits for the frame and remainder stores
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fvalid <= '0;
            r_rvalid <= '0;
        end else begin
            if (w_fwrite) begin
                r_fvalid[w_fwaddr] <= 1'b1;
            end
            if (w_step) begin
                r_rvalid[r_pos] <= 1'b1;
            end
        end
    end

    // Gamma table
    always_ff @(posedge i_clk) begin
        if (w_in_acc && (i_func == gtdf_pkg::FUNC_GAMMA)) begin
            r_gamma_mem[i_index] <= i_value;
        end
        if (r_state == S_GRD) begin
            r_gdata <= r_gamma_mem[w_pix];
        end
    end

    // Frame store, two banks
    always_ff @(posedge i_clk) begin
        if (w_fwrite) begin
            r_frame_mem[w_fwaddr] <= i_value[7:0];
        end
        if (r_state == S_FRD) begin
            r_fdata    <= r_frame_mem[w_fraddr];
            r_fdata_ok <= r_fvalid[w_fraddr];
        end
    end

    // Dither remainders
    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_rem_mem[r_pos] <= n_sum[7:0];
        end
        if (r_state == S_FRD) begin
            r_rdata    <= r_rem_mem[r_pos];
            r_rdata_ok <= r_rvalid[r_pos];
        end
    end

    assign o_valid    = r_out_valid;
    assign o_led_byte = r_out_byte;
    assign o_position = 6'(r_out_pos);
    assign o_last     = r_out_last;
    assign o_swapped  = r_out_swapped;

    // A swap flag only ever appears on the closing byte of a refresh.
    a_swap_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_swapped |-> o_last)
        else $error("swap flag on a byte other than the last");

    // The closing byte carries the final position of the frame.
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> (o_position == 6'(LAST_POS)))
        else $error("last flag at wrong position");

    // A frame swap clears the tick counter and the completion mark.
    a_swap_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_front) |-> (r_tick == 8'd0) && !r_frame_ready)
        else $error("swap left tick count or completion mark set");

    // An accepted tick starts the walk at the first byte.
    a_tick_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && (i_func == gtdf_pkg::FUNC_TICK) |=>
            (r_state == S_FRD) && (r_pos == '0))
        else $error("tick did not start the byte walk");

    // The front bank only changes as the last byte of a refresh is issued.
    a_swap_timing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_front) |-> $past(w_step && w_is_last))
        else $error("front bank changed outside the end of a refresh");

endmodule

>>> sim/gamma_temporal_dither_frame_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gamma_temporal_dither_frame_tb
// Self-checking bench for the double-buffered, gamma-corrected and temporally
// dithered LED frame store. A directed table and then random frame updates
// are fed through the request channel, while a behavioural predictor keeps
// its own gamma table, frame banks, remainders and swap counter and queues
// every LED byte that each refresh tick should produce.
// ----------------------------------------------------------------------------
module gamma_temporal_dither_frame_tb;

    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 30;
    localparam int HOLD_CYCLES   = 300;
    localparam int MAX_REPORTS   = 10;
    localparam int DIRECTED_ROWS = 26;

    typedef struct packed {
        bit              cfg;
        gtdf_pkg::t_func func;
        logic [7:0]      idx;
        logic [15:0]     val;
        bit              typed;
        logic [7:0]      level;
    } t_row;

    typedef struct packed {
        logic [7:0] led_byte;
        logic [5:0] position;
        logic       last;
        logic       swapped;
    } t_led_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_func;
    logic [7:0]  i_index;
    logic [15:0] i_value;
    logic        o_valid;
    logic        i_ready;
    logic [7:0]  o_led_byte;
    logic [5:0]  o_position;
    logic        o_last;
    logic        o_swapped;

    // Predictor state.
    logic [15:0] gamma_mem [256];
    bit          gamma_loaded [256];
    logic [7:0]  frame_mem [2*gtdf_pkg::BANK_SIZE];
    logic [7:0]  remainder [gtdf_pkg::BANK_SIZE];
    bit          front_bank;
    logic [7:0]  tick_count;
    bit          back_complete;
    logic [7:0]  tick_limit;

    t_led_result led_expect [$];
    int          mismatches = 0;
    int          requests_issued = 0;
    bit          hold_pending = 1'b0;
    bit          hold_active = 1'b0;

    // Directed table: cfg rows carry the new tick setting in val.
    t_row directed_rows [DIRECTED_ROWS] = '{
        '{1'b0, gtdf_pkg::FUNC_GAMMA, 8'h00, 16'h0000, 1'b0, 8'h00},
        '{1'b0, gtdf_pkg::FUNC_TICK,  8'h00, 16'h0000, 1'b1, 8'h00},
        '{1'b0, gtdf_pkg::FUNC_GAMMA, 8'h00, 16'hFFFF, 1'b0, 8'h00},
        '{1'b0, gtdf_pkg::FUNC_TICK,  8'hFF, 16'hFFFF, 1'b1, 8'hFF},
        '{1'b0, gtdf_pkg::FUNC_GAMMA, 8'hFF, 16'h8040, 1'b0, 8'h00},
        '{1'b0, gtdf_pkg::FUNC_GAMMA, 8'h5A, 16'h12C7, 1'b0, 8'h00},
        '{1'b0, gtdf_pkg::FUNC_WRITE, 8'h00, 16'h00FF, 1'b0, 8'h00},
        '{1'b0, gtdf_pkg::FUNC_WRITE, 8'h2F, 16'hFF5A, 1'b0, 8'h00},
        '{1'b0, gtdf_pkg::FUNC_WRITE, 8'h30, 16'h0012, 1'b0, 8'h00},
        '{1'b0, gtdf_pkg::FUNC_WRITE, 8'hFF, 16'hAB00, 1'b0, 8'h00},
        '{1'b0, gtdf_pkg::FUNC_DONE,  8'h00, 16'h0000, 1'b0, 8'h00},
        '{1'b0, gtdf_pkg::FUNC_TICK,  8'h00, 16'h0000, 1'b0, 8'h00},
        '{1'b0, gtdf_pkg::FUNC_TICK,  8'h00, 16'h0000, 1'b0, 8'h00},
        '{1'b0, gtdf_pkg::FUNC_TICK,  8'h00, 16'h0000, 1'b0, 8'h00},
        '{1'b0, gtdf_pkg::FUNC_GAMMA, 8'h80, 16'h0001, 1'b0, 8'h00},
        '{1'b0, gtdf_pkg::FUNC_WRITE, 8'h01, 16'h0080, 1'b0, 8'h00},
        '{1'b0, gtdf_pkg::FUNC_TICK,  8'h00, 16'h0000, 1'b0, 8'h00},
        '{1'b1, gtdf_pkg::FUNC_GAMMA, 8'h00, 16'h0000, 1'b0, 8'h00},
        '{1'b0, gtdf_pkg::FUNC_DONE,  8'h00, 16'h0000, 1'b0, 8'h00},
        '{1'b0, gtdf_pkg::FUNC_TICK,  8'h00, 16'h0000, 1'b0, 8'h00},
        '{1'b0, gtdf_pkg::FUNC_TICK,  8'h00, 16'h0000, 1'b0, 8'h00},
        '{1'b1, gtdf_pkg::FUNC_GAMMA, 8'h00, 16'h0001, 1'b0, 8'h00},
        '{1'b0, gtdf_pkg::FUNC_WRITE, 8'h02, 16'h0000, 1'b0, 8'h00},
        '{1'b0, gtdf_pkg::FUNC_DONE,  8'h00, 16'h0000, 1'b0, 8'h00},
        '{1'b0, gtdf_pkg::FUNC_TICK,  8'h00, 16'h0000, 1'b0, 8'h00},
        '{1'b0, gtdf_pkg::FUNC_TICK,  8'h00, 16'h0000, 1'b0, 8'h00}
    };

    gamma_temporal_dither_frame DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_func      (i_func),
        .i_index     (i_index),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_led_byte  (o_led_byte),
        .o_position  (o_position),
        .o_last      (o_last),
        .o_swapped   (o_swapped)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    initial begin
        #20_000_000;
        $display("gamma_temporal_dither_frame verification failed");
        $finish;
    end

    function automatic void reset_model();
        for (int i = 0; i < 256; i++) begin
            gamma_mem[i]    = 16'h0000;
            gamma_loaded[i] = 1'b0;
        end
        for (int i = 0; i < 2*gtdf_pkg::BANK_SIZE; i++) frame_mem[i] = 8'h00;
        for (int i = 0; i < gtdf_pkg::BANK_SIZE; i++)
            remainder[i] = 8'(gtdf_pkg::DITHER_STEP * (i + 1));
        front_bank    = 1'b0;
        tick_count    = 8'h00;
        back_complete = 1'b0;
        tick_limit    = gtdf_pkg::TPF_RESET;
    endfunction

    // Updates the predicted state for one accepted request and queues the
    // LED bytes of a refresh. A typed level replaces the predicted level.
    function automatic void apply_request(input gtdf_pkg::t_func f, input logic [7:0] idx,
                                          input logic [15:0] val, input bit typed,
                                          input logic [7:0] level);
        logic [7:0]  next_count;
        logic [8:0]  sum;
        logic [8:0]  lvl;
        logic [15:0] entry;
        bit          swap;
        t_led_result res;
        case (f)
            gtdf_pkg::FUNC_GAMMA: begin
                gamma_mem[idx]    = val;
                gamma_loaded[idx] = 1'b1;
            end
            gtdf_pkg::FUNC_WRITE: begin
                if (idx < gtdf_pkg::NUM_BYTES) frame_mem[{~front_bank, idx[5:0]}] = val[7:0];
            end
            gtdf_pkg::FUNC_DONE: begin
                back_complete = 1'b1;
            end
            gtdf_pkg::FUNC_TICK: begin
                // The swap decision does not depend on the walk itself.
                next_count = tick_count + 8'd1;
                swap = back_complete && (next_count >= tick_limit);
                for (int p = 0; p < gtdf_pkg::NUM_BYTES; p++) begin
                    entry = gamma_mem[frame_mem[{front_bank, 6'(p)}]];
                    sum = {1'b0, remainder[p]} + {1'b0, entry[7:0]};
                    remainder[p] = sum[7:0];
                    lvl = {1'b0, entry[15:8]} + {8'h00, sum[8]};
                    res.led_byte = lvl[8] ? 8'hFF : lvl[7:0];
                    if (typed) res.led_byte = level;
                    res.position = 6'(p);
                    res.last     = (p == gtdf_pkg::NUM_BYTES - 1);
                    res.swapped  = (p == gtdf_pkg::NUM_BYTES - 1) && swap;
                    led_expect.push_back(res);
                end
                if (swap) begin
                    front_bank    = ~front_bank;
                    tick_count    = 8'h00;
                    back_complete = 1'b0;
                end else begin
                    tick_count = next_count;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic int idle_len();
        int roll;
        roll = int'($urandom_range(0, 19));
        if (roll < 10) return 0;
        if (roll < 18) return int'($urandom_range(1, 3));
        return int'($urandom_range(12, 40));
    endfunction

    function automatic logic [15:0] random_gamma_entry();
        if ($urandom_range(0, 7) == 0) return {8'hFF, 8'($urandom)};
        return 16'($urandom);
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    // with valid still high, so that the next request can follow directly.
    task automatic push_request(input gtdf_pkg::t_func f, input logic [7:0] idx,
                                input logic [15:0] val, input bit typed = 1'b0,
                                input logic [7:0] level = 8'h00);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_func  <= f;
        i_index <= idx;
        i_value <= val;
        do @(posedge i_clk); while (!o_ready);
        apply_request(f, idx, val, typed, level);
        if (!(f == gtdf_pkg::FUNC_WRITE && idx >= gtdf_pkg::NUM_BYTES)) requests_issued++;
        @(negedge i_clk);
    endtask

    task automatic drain(input int settle);
        i_valid <= 1'b0;
        while (led_expect.size() != 0) @(negedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    task automatic set_ticks_per_frame(input logic [7:0] setting);
        drain(SETTLE_CYCLES);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= setting;
        do @(posedge i_clk); while (!o_cfg_ready);
        tick_limit = setting;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // A byte may only reach the frame once its gamma entry has been loaded.
    task automatic write_pixel(input logic [7:0] idx, input logic [15:0] val);
        if (!gamma_loaded[val[7:0]])
            push_request(gtdf_pkg::FUNC_GAMMA, val[7:0], random_gamma_entry());
        push_request(gtdf_pkg::FUNC_WRITE, idx, val);
    endtask

    task automatic frame_update_burst();
        int n;
        n = int'($urandom_range(2, 6));
        repeat (n) write_pixel(8'($urandom_range(0, gtdf_pkg::NUM_BYTES - 1)), 16'($urandom));
        push_request(gtdf_pkg::FUNC_DONE, 8'($urandom), 16'($urandom));
        n = int'($urandom_range(1, 3));
        repeat (n) push_request(gtdf_pkg::FUNC_TICK, 8'($urandom), 16'($urandom));
    endtask

    task automatic stray_request();
        logic [7:0] idx;
        idx = 8'($urandom);
        case ($urandom_range(0, 3))
            0: push_request(gtdf_pkg::FUNC_GAMMA, idx, random_gamma_entry());
            1: begin
                if (idx < gtdf_pkg::NUM_BYTES) write_pixel(idx, 16'($urandom));
                else push_request(gtdf_pkg::FUNC_WRITE, idx, 16'($urandom));
            end
            2: push_request(gtdf_pkg::FUNC_DONE, idx, 16'($urandom));
            default: push_request(gtdf_pkg::FUNC_TICK, idx, 16'($urandom));
        endcase
    endtask

    task automatic random_phase(input int quota);
        int target;
        target = requests_issued + quota;
        while (requests_issued < target) begin
            if ($urandom_range(0, 3) != 0) frame_update_burst();
            else stray_request();
        end
    endtask

    task automatic log_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("%s", msg);
    endtask

    always @(posedge i_clk) begin : result_check
        t_led_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (led_expect.size() == 0) begin
                log_mismatch($sformatf("unexpected LED byte: led %0d pos %0d last %0d swap %0d",
                                       o_led_byte, o_position, o_last, o_swapped));
            end else begin
                want = led_expect.pop_front();
                if (o_led_byte !== want.led_byte || o_position !== want.position ||
                    o_last !== want.last || o_swapped !== want.swapped) begin
                    log_mismatch($sformatf({"LED byte mismatch: expected led %0d pos %0d ",
                                            "last %0d swap %0d, got led %0d pos %0d ",
                                            "last %0d swap %0d"},
                                           want.led_byte, want.position, want.last,
                                           want.swapped, o_led_byte, o_position,
                                           o_last, o_swapped));
                end
            end
        end
    end

    // Result side: random runs of readiness, broken by short or long stalls,
    // and a long hold-off whenever the stimulus asks for one.
    initial begin : result_sink
        int run;
        int gap;
        run = 0;
        gap = 0;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_active) begin
                i_ready <= 1'b0;
            end else if (gap > 0) begin
                i_ready <= 1'b0;
                gap--;
            end else begin
                i_ready <= 1'b1;
                if (run > 0) begin
                    run--;
                end else begin
                    run = int'($urandom_range(1, 12));
                    gap = idle_len();
                end
            end
        end
    end

    initial begin : output_hold
        forever begin
            wait (hold_pending);
            hold_pending = 1'b0;
            @(posedge i_clk);
            hold_active = 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            hold_active = 1'b0;
        end
    end

    initial begin : stimulus
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = 8'h00;
        i_valid     = 1'b0;
        i_func      = gtdf_pkg::FUNC_GAMMA;
        i_index     = 8'h00;
        i_value     = 16'h0000;
        reset_model();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            if (directed_rows[r].cfg)
                set_ticks_per_frame(directed_rows[r].val[7:0]);
            else
                push_request(directed_rows[r].func, directed_rows[r].idx,
                             directed_rows[r].val, directed_rows[r].typed,
                             directed_rows[r].level);
        end

        set_ticks_per_frame(8'($urandom_range(1, 6)));
        random_phase(25);

        // Hold the result side off while refreshes keep arriving.
        set_ticks_per_frame(8'($urandom_range(1, 6)));
        hold_pending = 1'b1;
        repeat (3) push_request(gtdf_pkg::FUNC_TICK, 8'($urandom), 16'($urandom));
        random_phase(24);

        set_ticks_per_frame(8'($urandom_range(1, 6)));
        random_phase(25);

        drain(TAIL_CYCLES);
        if (mismatches == 0) begin
            $display("gamma_temporal_dither_frame verification clean");
        end else begin
            $display("gamma_temporal_dither_frame verification failed");
        end
        $finish;
    end

endmodule
